### rtl/aes256_pkg.sv
// Package for the AES-256 block encrypt core: constants, types and round functions.
// Depends on nothing; used by every module in rtl/.
package aes256_pkg;

	localparam int KeyWords  = 8;
	localparam int NumRounds = 14;
	localparam int IdxW      = 3;

	typedef logic [31:0]  word_t;
	typedef logic [127:0] block_t;
	typedef logic [255:0] key_t;

	typedef enum logic [IdxW-1:0] {
		REG_KEY_W0 = 3'd0,
		REG_KEY_W1 = 3'd1,
		REG_KEY_W2 = 3'd2,
		REG_KEY_W3 = 3'd3,
		REG_KEY_W4 = 3'd4,
		REG_KEY_W5 = 3'd5,
		REG_KEY_W6 = 3'd6,
		REG_KEY_W7 = 3'd7
	} reg_idx_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic word_t sub_word(input word_t w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// byte 4c+r sits at bits [32c+8r +: 8]
	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[32*c+8*r +: 8] = SBOX[s[32*((c+r)%4)+8*r +: 8]];
		sub_shift = t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0  = s[32*c +: 8];
			a1  = s[32*c+8 +: 8];
			a2  = s[32*c+16 +: 8];
			a3  = s[32*c+24 +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[32*c    +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[32*c+8  +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		mix_columns = t;
	endfunction

	// advance the 8-word key window by one half-step pair (8 words), rcon given
	function automatic key_t key_step(input key_t k, input logic [7:0] rcon);
		word_t w [16];
		word_t t;
		for (int n = 0; n < 8; n++)
			w[n] = k[32*n +: 32];
		for (int n = 8; n < 16; n++) begin
			t = w[n-1];
			if (n == 8)
				t = sub_word({t[7:0], t[31:8]}) ^ {24'h0, rcon};
			else if (n == 12)
				t = sub_word(t);
			w[n] = w[n-8] ^ t;
		end
		for (int n = 0; n < 8; n++)
			key_step[32*n +: 32] = w[n+8];
	endfunction

endpackage

### rtl/aes256_round.sv
// One pipelined AES round stage: state and key window move together.
// Depends on aes256_pkg.
module aes256_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                valid_in,
	input  aes256_pkg::block_t  state_in,
	input  aes256_pkg::key_t    key_in,
	input  logic                last,
	input  logic                odd,
	input  logic [7:0]          rcon,
	output logic                valid_s1,
	output aes256_pkg::block_t  state_s1,
	output aes256_pkg::key_t    key_s1
);
	import aes256_pkg::*;

	block_t ss;
	block_t mixed;
	block_t rk;
	key_t   next_key;

	// odd round uses upper half of window, even round steps window and uses its lower half
	always_comb begin
		next_key = odd ? key_in : key_step(key_in, rcon);
		rk       = odd ? key_in[255:128] : next_key[127:0];
		ss       = sub_shift(state_in);
		mixed    = last ? ss : mix_columns(ss);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s1 <= mixed ^ rk;
			key_s1   <= next_key;
		end
	end

endmodule

### rtl/aes256_block_encrypt_core.sv
// Top level of the AES-256 block encrypt core: key registers and a 15-stage pipeline.
// Depends on aes256_pkg and aes256_round.
//
//   channel  | handshake           | payload
//   cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data (key words 0..7)
//   in       | in_valid/in_stall   | plain_w0..plain_w3
//   out      | out_valid/out_stall | cipher_w0..cipher_w3
//
// One stage does the initial key add and one each round; the key schedule runs
// alongside the data in each stage. One block enters per cycle while in_stall is low.
// Reset clears valid bits and key registers to zero. A stall on out holds only stages
// with no bubble after them; a bubble is squeezed out, so in_stall needs a full pipe.
module aes256_block_encrypt_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  aes256_pkg::word_t   cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  aes256_pkg::word_t   plain_w0,
	input  aes256_pkg::word_t   plain_w1,
	input  aes256_pkg::word_t   plain_w2,
	input  aes256_pkg::word_t   plain_w3,
	output logic                out_valid,
	input  logic                out_stall,
	output aes256_pkg::word_t   cipher_w0,
	output aes256_pkg::word_t   cipher_w1,
	output aes256_pkg::word_t   cipher_w2,
	output aes256_pkg::word_t   cipher_w3
);
	import aes256_pkg::*;

	localparam logic [7:0] RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

	key_t   key_q;
	logic   v   [NumRounds+1];
	block_t st  [NumRounds+1];
	key_t   kw  [NumRounds+1];
	logic   adv [NumRounds+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEY_W0: key_q[31:0]    <= cfg_data;
				REG_KEY_W1: key_q[63:32]   <= cfg_data;
				REG_KEY_W2: key_q[95:64]   <= cfg_data;
				REG_KEY_W3: key_q[127:96]  <= cfg_data;
				REG_KEY_W4: key_q[159:128] <= cfg_data;
				REG_KEY_W5: key_q[191:160] <= cfg_data;
				REG_KEY_W6: key_q[223:192] <= cfg_data;
				REG_KEY_W7: key_q[255:224] <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage advances if its output is empty or will move on
	always_comb begin
		adv[NumRounds] = !v[NumRounds] || !out_stall;
		for (int i = NumRounds - 1; i >= 0; i--)
			adv[i] = !v[i] || adv[i+1];
	end

	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (adv[0]) begin
			v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			st[0] <= {plain_w3, plain_w2, plain_w1, plain_w0} ^ key_q[127:0];
			kw[0] <= key_q;
		end
	end

	for (genvar r = 1; r <= NumRounds; r++) begin : g_round
		aes256_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (adv[r]),
			.valid_in (v[r-1]),
			.state_in (st[r-1]),
			.key_in   (kw[r-1]),
			.last     (r == NumRounds),
			.odd      (r % 2 == 1),
			.rcon     (RCON[(r/2 + 6) % 7]),
			.valid_s1 (v[r]),
			.state_s1 (st[r]),
			.key_s1   (kw[r])
		);
	end

	assign out_valid = v[NumRounds];
	assign cipher_w0 = st[NumRounds][31:0];
	assign cipher_w1 = st[NumRounds][63:32];
	assign cipher_w2 = st[NumRounds][95:64];
	assign cipher_w3 = st[NumRounds][127:96];

endmodule

### verif/tb_aes256_block_encrypt_core.sv
// Testbench for aes256_block_encrypt_core: AES-256 encryption of random and corner blocks
// under several keys, checked against an in-bench cipher model. Depends on aes256_pkg.
module tb_aes256_block_encrypt_core;
	timeunit 1ns;
	timeprecision 1ps;

	import aes256_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	word_t       cfg_data;
	logic        in_valid;
	logic        in_stall;
	word_t       plain_w0, plain_w1, plain_w2, plain_w3;
	logic        out_valid;
	logic        out_stall;
	word_t       cipher_w0, cipher_w1, cipher_w2, cipher_w3;

	aes256_block_encrypt_core dut (.*);

	block_t pending_blocks [$];
	block_t cipher_expected [$];
	key_t   cur_key;
	int     mismatches;
	int     in_gap;
	int     out_gap;
	bit     no_idle;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic word_t subst_word(word_t w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [7:0] gf_double(logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t aes256_encrypt(block_t pt, key_t key);
		word_t      sched [60];
		word_t      t;
		logic [7:0] rc;
		logic [7:0] st [16];
		logic [7:0] nx [16];
		logic [7:0] a0, a1, a2, a3, x;
		block_t     ct;
		rc = 8'h01;
		for (int n = 0; n < 8; n++)
			sched[n] = key[32*n +: 32];
		for (int n = 8; n < 60; n++) begin
			t = sched[n-1];
			if (n % 8 == 0) begin
				t = subst_word({t[7:0], t[31:8]}) ^ {24'h0, rc};
				rc = gf_double(rc);
			end else if (n % 8 == 4) begin
				t = subst_word(t);
			end
			sched[n] = sched[n-8] ^ t;
		end
		for (int i = 0; i < 16; i++)
			st[i] = pt[8*i +: 8] ^ sched[i/4][8*(i%4) +: 8];
		for (int rnd = 1; rnd <= 14; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					nx[4*c+r] = SBOX[st[4*((c+r)%4)+r]];
			if (rnd < 14) begin
				for (int c = 0; c < 4; c++) begin
					a0 = nx[4*c]; a1 = nx[4*c+1]; a2 = nx[4*c+2]; a3 = nx[4*c+3];
					x = a0 ^ a1 ^ a2 ^ a3;
					nx[4*c]   = a0 ^ x ^ gf_double(a0 ^ a1);
					nx[4*c+1] = a1 ^ x ^ gf_double(a1 ^ a2);
					nx[4*c+2] = a2 ^ x ^ gf_double(a2 ^ a3);
					nx[4*c+3] = a3 ^ x ^ gf_double(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				st[i] = nx[i] ^ sched[4*rnd + i/4][8*(i%4) +: 8];
		end
		for (int i = 0; i < 16; i++)
			ct[8*i +: 8] = st[i];
		return ct;
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		$display("mismatch %s: got %08h want %08h", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			plain_w0 <= '0; plain_w1 <= '0; plain_w2 <= '0; plain_w3 <= '0;
			in_gap   <= 0;
		end else begin
			if (in_valid && !in_stall)
				cipher_expected.push_back(
					aes256_encrypt({plain_w3, plain_w2, plain_w1, plain_w0}, cur_key));
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap   <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_blocks.size() > 0) begin
					block_t b;
					b = pending_blocks.pop_front();
					{plain_w3, plain_w2, plain_w1, plain_w0} <= b;
					in_valid <= 1'b1;
					in_gap   <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cipher_expected.size() == 0) begin
					report_mismatch("unexpected transaction cipher_w0", cipher_w0, 'x);
				end else begin
					block_t want;
					want = cipher_expected.pop_front();
					if (cipher_w0 !== want[31:0])   report_mismatch("cipher_w0", cipher_w0, want[31:0]);
					if (cipher_w1 !== want[63:32])  report_mismatch("cipher_w1", cipher_w1, want[63:32]);
					if (cipher_w2 !== want[95:64])  report_mismatch("cipher_w2", cipher_w2, want[95:64]);
					if (cipher_w3 !== want[127:96]) report_mismatch("cipher_w3", cipher_w3, want[127:96]);
				end
			end
			if (out_gap > 0) begin
				out_gap   <= out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				out_gap   <= pick_gap();
			end
		end
	end

	task automatic write_key_word(reg_idx_t idx, word_t value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cur_key[32*idx +: 32] = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic load_key(key_t key);
		reg_idx_t idx;
		idx = idx.first();
		for (int n = 0; n < KeyWords; n++) begin
			write_key_word(idx, key[32*n +: 32]);
			idx = idx.next();
		end
	endtask

	task automatic drain();
		while (pending_blocks.size() > 0 || in_valid || cipher_expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic block_t rand_block();
		return {$urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	function automatic key_t rand_key();
		key_t k;
		for (int n = 0; n < 8; n++)
			k[32*n +: 32] = $urandom();
		return k;
	endfunction

	initial begin
		#5_000_000;
		$display("tb_aes256_block_encrypt_core NOT OK");
		$finish;
	end

	initial begin
		mismatches = 0;
		cur_key    = '0;
		no_idle    = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// key never written: all-zero key
		pending_blocks.push_back('0);
		pending_blocks.push_back('1);
		pending_blocks.push_back(128'h00112233_44556677_8899aabb_ccddeeff);
		for (int i = 0; i < 8; i++)
			pending_blocks.push_back(block_t'(1) << (16 * i + i));
		drain();

		load_key('1);
		pending_blocks.push_back('0);
		pending_blocks.push_back('1);
		pending_blocks.push_back({4{32'h8000_0001}});
		drain();

		load_key(256'h1f1e1d1c_1b1a1918_17161514_13121110_0f0e0d0c_0b0a0908_07060504_03020100);
		pending_blocks.push_back(128'hffeeddcc_bbaa9988_77665544_33221100);
		pending_blocks.push_back('0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph % 3 == 2);
			if (ph == 5)
				load_key('0);
			else
				load_key(rand_key());
			for (int i = 0; i < 78; i++)
				pending_blocks.push_back(rand_block());
			drain();
		end

		if (mismatches == 0)
			$display("tb_aes256_block_encrypt_core OK");
		else
			$display("tb_aes256_block_encrypt_core NOT OK");
		$finish;
	end

endmodule
